// File: hw/rtl/pcle_pkg.sv
// ============================================================================
// pcle_pkg: shared types and constants of the positional circular list engine
// Request and result payloads, request and status codes, sequencer states.
// ============================================================================
package pcle_pkg;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;

    // A traverse reports at most this many elements.
    localparam int MAX_RESULTS = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DELETE   = 2'd1,
        KIND_SEARCH   = 2'd2,
        KIND_TRAVERSE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_SRCH,
        S_TRD,
        S_TEMIT,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_kind                   kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] element;
        logic [POS_W-1:0]        slot;
        logic                    last;
    } t_res;

endpackage

// File: hw/rtl/pcle_req_if.sv
// ============================================================================
// pcle_req_if: request channel
// Valid/ready channel carrying one list request per transfer.
// ============================================================================
interface pcle_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  position;
    logic signed [31:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

// File: hw/rtl/pcle_res_if.sv
// ============================================================================
// pcle_res_if: result channel
// Valid/ready channel carrying one result per transfer.
// ============================================================================
interface pcle_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] element;
    logic [5:0]  slot;
    logic        last;

    modport source (output valid, status, element, slot, last, input ready);
    modport sink   (input valid, status, element, slot, last, output ready);
endinterface

// File: hw/rtl/pcle_ram.sv
// ============================================================================
// pcle_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module pcle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pcle_seq.sv
// ============================================================================
// pcle_seq: list sequencer
// Walks the list memory one entry per cycle to shift and search, and entry by entry to traverse.
// ============================================================================
module pcle_seq #(
    parameter int DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  pcle_pkg::t_req  i_req,
    input  logic            i_out_free,
    output logic            o_push,
    output pcle_pkg::t_res  o_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int PW   = pcle_pkg::POS_W;
    localparam int VW   = pcle_pkg::VAL_W;
    localparam int CMPW = ((CW > PW) ? CW : PW) + 1;

    pcle_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [PW-1:0]     r_pos, n_pos;
    logic [VW-1:0]     r_val, n_val;
    logic              r_pend, n_pend;
    logic              r_pend_wr, n_pend_wr;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_hit, n_hit;
    pcle_pkg::t_status r_status, n_status;
    logic [VW-1:0]     r_elem, n_elem;
    logic [PW-1:0]     r_slot, n_slot;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [VW-1:0]     ram_rdata;

    logic              accept;
    logic [CMPW-1:0]   w_cnt, w_idx, w_pos, w_req_pos;
    logic              list_empty, ins_bad, ins_full, del_bad;
    logic              ins_go, del_go, walk_go, trav_last;

    assign accept     = i_req_valid && o_req_ready;
    assign w_cnt      = CMPW'(r_count);
    assign w_idx      = CMPW'(r_idx);
    assign w_pos      = CMPW'(r_pos);
    assign w_req_pos  = CMPW'(i_req.position);
    assign list_empty = (r_count == '0);
    assign ins_bad    = (i_req.position == '0) || (w_req_pos > w_cnt + CMPW'(1));
    assign ins_full   = (w_cnt >= CMPW'(DEPTH));
    assign del_bad    = (i_req.position == '0) || (w_req_pos > w_cnt);

    // Insert copies entry idx-1 up to idx while idx has not gone below the position.
    assign ins_go    = (w_idx >= w_pos);
    // Delete reads from position-1 through count-1; search reads the whole list.
    assign del_go    = (w_idx < w_cnt);
    assign walk_go   = (w_idx < w_cnt);
    assign trav_last = (w_idx + CMPW'(1) == w_cnt) ||
                       (w_idx + CMPW'(1) == CMPW'(pcle_pkg::MAX_RESULTS));

    pcle_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcle_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.kind)
                        pcle_pkg::KIND_INSERT: begin
                            n_state = (ins_bad || ins_full) ? pcle_pkg::S_REPORT
                                                            : pcle_pkg::S_INS;
                        end
                        pcle_pkg::KIND_DELETE: begin
                            n_state = (list_empty || del_bad) ? pcle_pkg::S_REPORT
                                                              : pcle_pkg::S_DEL;
                        end
                        pcle_pkg::KIND_SEARCH: begin
                            n_state = list_empty ? pcle_pkg::S_REPORT : pcle_pkg::S_SRCH;
                        end
                        default: begin
                            n_state = list_empty ? pcle_pkg::S_REPORT : pcle_pkg::S_TRD;
                        end
                    endcase
                end
            end
            pcle_pkg::S_INS: begin
                if (!ins_go && !r_pend) begin
                    n_state = pcle_pkg::S_REPORT;
                end
            end
            pcle_pkg::S_DEL: begin
                if (!del_go && !r_pend) begin
                    n_state = pcle_pkg::S_REPORT;
                end
            end
            pcle_pkg::S_SRCH: begin
                if (!walk_go && !r_pend) begin
                    n_state = pcle_pkg::S_REPORT;
                end
            end
            pcle_pkg::S_TRD: begin
                if (i_out_free) begin
                    n_state = pcle_pkg::S_TEMIT;
                end
            end
            pcle_pkg::S_TEMIT: begin
                n_state = trav_last ? pcle_pkg::S_IDLE : pcle_pkg::S_TRD;
            end
            pcle_pkg::S_REPORT: begin
                if (i_out_free) begin
                    n_state = pcle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcle_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshake, result push and memory port control.
    always_comb begin
        o_req_ready = (r_state == pcle_pkg::S_IDLE);
        o_push      = 1'b0;
        o_res       = '{status: r_status, element: r_elem, slot: r_slot, last: 1'b1};
        ram_we      = r_pend && r_pend_wr;
        ram_waddr   = r_wr_addr;
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;
        case (r_state)
            pcle_pkg::S_INS: begin
                if (ins_go) begin
                    ram_raddr = AW'(r_idx - CW'(1));
                end else if (!r_pend) begin
                    // The shift is done: the new value lands at position-1.
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_idx);
                    ram_wdata = r_val;
                end
            end
            pcle_pkg::S_DEL, pcle_pkg::S_SRCH: begin
                ram_raddr = AW'(r_idx);
            end
            pcle_pkg::S_TRD: begin
                ram_raddr = AW'(r_idx);
            end
            pcle_pkg::S_TEMIT: begin
                o_push = 1'b1;
                o_res  = '{status:  pcle_pkg::ST_OK,
                           element: ram_rdata,
                           slot:    PW'(w_idx + CMPW'(1)),
                           last:    trav_last};
            end
            pcle_pkg::S_REPORT: begin
                o_push = i_out_free;
            end
            default: begin
            end
        endcase
    end

    // Next values of the working registers.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_val     = r_val;
        n_pend    = 1'b0;
        n_pend_wr = 1'b0;
        n_wr_addr = r_wr_addr;
        n_hit     = r_hit;
        n_status  = r_status;
        n_elem    = r_elem;
        n_slot    = r_slot;
        case (r_state)
            pcle_pkg::S_IDLE: begin
                if (accept) begin
                    n_pos    = i_req.position;
                    n_val    = i_req.value;
                    n_hit    = 1'b0;
                    n_elem   = '0;
                    n_slot   = '0;
                    n_idx    = '0;
                    n_status = pcle_pkg::ST_OK;
                    case (i_req.kind)
                        pcle_pkg::KIND_INSERT: begin
                            if (ins_bad) begin
                                n_status = pcle_pkg::ST_BADPOS;
                            end else if (ins_full) begin
                                n_status = pcle_pkg::ST_FULL;
                            end else begin
                                n_elem = i_req.value;
                                n_slot = i_req.position;
                                n_idx  = r_count;
                            end
                        end
                        pcle_pkg::KIND_DELETE: begin
                            if (list_empty) begin
                                n_status = pcle_pkg::ST_EMPTY;
                            end else if (del_bad) begin
                                n_status = pcle_pkg::ST_BADPOS;
                            end else begin
                                n_slot = i_req.position;
                                n_idx  = CW'(w_req_pos - CMPW'(1));
                            end
                        end
                        default: begin
                            if (list_empty) begin
                                n_status = pcle_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            pcle_pkg::S_INS: begin
                if (ins_go) begin
                    n_pend    = 1'b1;
                    n_pend_wr = 1'b1;
                    n_wr_addr = AW'(r_idx);
                    n_idx     = r_idx - CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count + CW'(1);
                end
            end
            pcle_pkg::S_DEL: begin
                if (r_pend && !r_pend_wr) begin
                    n_elem = ram_rdata;
                end
                if (del_go) begin
                    // The first read fetches the removed value; later reads move down.
                    n_pend    = 1'b1;
                    n_pend_wr = (w_idx != w_pos - CMPW'(1));
                    n_wr_addr = AW'(r_idx - CW'(1));
                    n_idx     = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                end
            end
            pcle_pkg::S_SRCH: begin
                if (r_pend && (ram_rdata == r_val)) begin
                    n_hit = 1'b1;
                end
                if (walk_go) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_status = r_hit ? pcle_pkg::ST_OK : pcle_pkg::ST_NOTFOUND;
                end
            end
            pcle_pkg::S_TEMIT: begin
                n_idx = r_idx + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcle_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_pend_wr <= n_pend_wr;
        r_wr_addr <= n_wr_addr;
        r_hit     <= n_hit;
        r_status  <= n_status;
        r_elem    <= n_elem;
        r_slot    <= n_slot;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count exceeds the list depth");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("result pushed while the output register is occupied");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != pcle_pkg::S_IDLE))
        else $error("request accepted but the sequencer stayed idle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ((r_count == $past(r_count) + CW'(1)) || (r_count + CW'(1) == $past(r_count))))
        else $error("element count moved by more than one");

endmodule

// File: hw/rtl/positional_circular_list_engine.sv
// ============================================================================
// positional_circular_list_engine: ordered list of signed 32-bit values
// Insert and delete by 1-based position, search by value, and traverse.
// ============================================================================
//
//  Channel  Direction  Transfer carries
//  i_req    in         kind, position, value
//  o_res    out        status, element, slot, last
//
// The list memory has one read and one write port. Insert, delete and
// search walk it one entry per cycle; traverse reads one entry at a time
// and waits for a free output register before it pushes each element.
// Reset clears the element count; the memory contents need no clearing.
// A result waits in the output register; the engine stalls only when it
// must push another result while that register is still occupied.
// ============================================================================
module positional_circular_list_engine #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcle_req_if.sink    i_req,
    pcle_res_if.source  o_res
);

    pcle_pkg::t_req req;
    pcle_pkg::t_res seq_res;
    pcle_pkg::t_res r_out;
    logic           r_out_valid;
    logic           seq_push;
    logic           out_free;
    logic           seq_ready;

    assign req = '{kind:     pcle_pkg::t_kind'(i_req.kind),
                   position: i_req.position,
                   value:    i_req.value};

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = seq_ready;

    pcle_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (seq_ready),
        .i_req       (req),
        .i_out_free  (out_free),
        .o_push      (seq_push),
        .o_res       (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_push) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_push) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out.status;
    assign o_res.element = r_out.element;
    assign o_res.slot    = r_out.slot;
    assign o_res.last    = r_out.last;

endmodule

// File: sim/pcle_list_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pcle_list_checker: result predictor and scoreboard for the list engine
// Watches both channels, keeps its own image of the stored list, works out
// the results of every request transfer and compares them, in order, with
// the result transfers of the engine.
// ============================================================================
module pcle_list_checker #(
    parameter int DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pcle_req_if  i_req,
    pcle_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import pcle_pkg::*;

    logic signed [VAL_W-1:0] list_image[$];
    t_res                    expected_results[$];
    int                      fail_count = 0;

    function automatic void push_expected(t_status status, logic signed [VAL_W-1:0] element,
                                          logic [POS_W-1:0] slot, logic last);
        t_res r;
        r.status  = status;
        r.element = element;
        r.slot    = slot;
        r.last    = last;
        expected_results.push_back(r);
    endfunction

    function automatic void apply_list_request(t_kind kind, logic [POS_W-1:0] position,
                                               logic signed [VAL_W-1:0] value);
        int                      count;
        int                      pos;
        int                      emitted;
        bit                      hit;
        logic signed [VAL_W-1:0] removed;
        count = list_image.size();
        pos   = int'(position);
        case (kind)
            KIND_INSERT: begin
                if (pos == 0 || pos > count + 1) begin
                    push_expected(ST_BADPOS, '0, '0, 1'b1);
                end else if (count >= DEPTH) begin
                    push_expected(ST_FULL, '0, '0, 1'b1);
                end else begin
                    list_image.insert(pos - 1, value);
                    push_expected(ST_OK, value, position, 1'b1);
                end
            end
            KIND_DELETE: begin
                if (count == 0) begin
                    push_expected(ST_EMPTY, '0, '0, 1'b1);
                end else if (pos == 0 || pos > count) begin
                    push_expected(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                    removed = list_image[pos - 1];
                    list_image.delete(pos - 1);
                    push_expected(ST_OK, removed, position, 1'b1);
                end
            end
            KIND_SEARCH: begin
                if (count == 0) begin
                    push_expected(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    hit = 1'b0;
                    foreach (list_image[i])
                        if (list_image[i] == value) hit = 1'b1;
                    push_expected(hit ? ST_OK : ST_NOTFOUND, '0, '0, 1'b1);
                end
            end
            default: begin
                if (count == 0) begin
                    push_expected(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    // A long list is cut off after the result limit.
                    emitted = (count < MAX_RESULTS) ? count : MAX_RESULTS;
                    for (int i = 0; i < emitted; i++)
                        push_expected(ST_OK, list_image[i], POS_W'(i + 1), i + 1 == emitted);
                end
            end
        endcase
    endfunction

    function automatic void flag_field(string field, longint want, longint got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endfunction

    function automatic void check_result();
        t_res want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d element %0d slot %0d last %0d",
                     $time, i_res.status, i_res.element, i_res.slot, i_res.last);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (i_res.status !== want.status)
                flag_field("status", want.status, i_res.status);
            if (i_res.element !== want.element)
                flag_field("element", want.element, i_res.element);
            if (i_res.slot !== want.slot)
                flag_field("slot", want.slot, i_res.slot);
            if (i_res.last !== want.last)
                flag_field("last", want.last, i_res.last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_image.delete();
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                apply_list_request(t_kind'(i_req.kind), i_req.position, i_req.value);
            if (i_res.valid && i_res.ready)
                check_result();
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: sim/positional_circular_list_engine_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// positional_circular_list_engine_tb: testbench of the list engine
// Drives a directed set of corner requests and then phases of random list
// traffic that fill, drain and churn the store, with random idling on both
// channels. The checker beside the engine predicts and compares results.
// ============================================================================
module positional_circular_list_engine_tb;
    import pcle_pkg::*;

    localparam int LIST_DEPTH    = 32;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 16;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum int {PH_GROW, PH_SHRINK, PH_CHURN} t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcle_req_if req_ch();
    pcle_res_if res_ch();

    int fail_count;
    int pending;
    bit bursts_on;

    // Length of the list as the stimulus sees it, used only to aim positions.
    int                      list_len = 0;
    logic signed [VAL_W-1:0] inserted_vals[8];
    int                      inserted_wr = 0;

    positional_circular_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    pcle_list_checker #(
        .DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: random stalls in bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input t_kind kind, input logic [POS_W-1:0] position,
                                input logic signed [VAL_W-1:0] value);
        int pos;
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.position <= position;
        req_ch.value    <= value;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        pos = int'(position);
        if (kind == KIND_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < LIST_DEPTH) begin
            list_len++;
            inserted_vals[inserted_wr] = value;
            inserted_wr = (inserted_wr + 1) % 8;
        end else if (kind == KIND_DELETE && pos >= 1 && pos <= list_len) begin
            list_len--;
        end
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom_range(0, 15);
        if (roll < 50) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_request(input t_phase phase);
        int                      roll;
        int                      ins_pct;
        int                      del_pct;
        t_kind                   kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        ins_pct = (phase == PH_GROW) ? 80 : (phase == PH_SHRINK) ? 10 : 35;
        del_pct = (phase == PH_GROW) ? 5 : (phase == PH_SHRINK) ? 70 : 35;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            kind = KIND_INSERT;
        else if (roll < ins_pct + del_pct)
            kind = KIND_DELETE;
        else if (roll < 92)
            kind = KIND_SEARCH;
        else
            kind = KIND_TRAVERSE;

        roll = $urandom_range(0, 99);
        if (roll < 10 || (kind == KIND_DELETE && list_len == 0)) begin
            position = POS_W'($urandom_range(0, 63));
        end else if (kind == KIND_INSERT) begin
            if (roll < 20)
                position = POS_W'(1);
            else if (roll < 30)
                position = POS_W'(list_len + 1);
            else
                position = POS_W'($urandom_range(1, list_len + 1));
        end else if (kind == KIND_DELETE) begin
            if (roll < 20)
                position = POS_W'(1);
            else if (roll < 30)
                position = POS_W'(list_len);
            else
                position = POS_W'($urandom_range(1, list_len));
        end else begin
            position = POS_W'($urandom_range(0, 63));
        end

        if (kind == KIND_SEARCH && $urandom_range(0, 1) == 0)
            value = inserted_vals[$urandom_range(0, 7)];
        else
            value = pick_value();
        send_request(kind, position, value);
    endtask

    initial begin
        foreach (inserted_vals[i]) inserted_vals[i] = '0;
        req_ch.valid    <= 1'b0;
        req_ch.kind     <= KIND_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        bursts_on       <= 1'b1;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list, bad positions, extreme values and the ends of the list.
        send_request(KIND_TRAVERSE, 6'd1, 32'sd0);
        send_request(KIND_DELETE, 6'd1, 32'sd0);
        send_request(KIND_SEARCH, 6'd0, 32'sd5);
        send_request(KIND_INSERT, 6'd0, 32'sd7);
        send_request(KIND_INSERT, 6'd2, 32'sd7);
        send_request(KIND_INSERT, 6'd1, VAL_MIN);
        send_request(KIND_INSERT, 6'd2, VAL_MAX);
        send_request(KIND_INSERT, 6'd1, -32'sd1);
        send_request(KIND_INSERT, 6'd2, 32'sd0);
        send_request(KIND_INSERT, 6'd63, 32'sd9);
        send_request(KIND_SEARCH, 6'd63, VAL_MAX);
        send_request(KIND_SEARCH, 6'd0, 32'sd12345);
        send_request(KIND_TRAVERSE, 6'd63, VAL_MIN);
        send_request(KIND_DELETE, 6'd0, 32'sd0);
        send_request(KIND_DELETE, 6'd5, 32'sd0);
        send_request(KIND_DELETE, 6'd63, -32'sd1);
        send_request(KIND_DELETE, 6'd4, 32'sd0);
        send_request(KIND_DELETE, 6'd1, 32'sd0);
        send_request(KIND_SEARCH, 6'd1, VAL_MAX);
        send_request(KIND_SEARCH, 6'd1, VAL_MIN);
        send_request(KIND_TRAVERSE, 6'd0, 32'sd0);
        wait_for_drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // The closing phases run without any idling.
            bursts_on <= (phase == 0) || (phase < PHASE_COUNT - 2 && $urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request(t_phase'(phase % 3));
            if (phase == 1 || $urandom_range(0, 1) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** positional_circular_list_engine: PASSED **");
        end else begin
            $display("** positional_circular_list_engine: FAILED **");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("** positional_circular_list_engine: FAILED **");
        $finish;
    end

endmodule
